// ===== design/bss_pkg.sv =====
package bss_pkg;

    localparam int BYTE_W    = 8;
    localparam int PAT_W     = 64;
    localparam int LEN_W     = 4;
    localparam int POS_W     = 17;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_MATCH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LAST   = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              last_byte;
    } bss_in_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             overflow;
    } bss_out_t;

    // True when the window byte sitting 'back' places behind the newest one
    // agrees with the pattern, or lies outside the active pattern length.
    function automatic logic byte_ok(
        input logic [PAT_W-1:0]  pattern,
        input logic [LEN_W-1:0]  len,
        input logic [2:0]        back,
        input logic [BYTE_W-1:0] wnd_byte
    );
        logic [LEN_W-1:0] sel;
        logic             ok;
        sel = len - 4'd1 - {1'b0, back};
        if ({1'b0, back} >= len) begin
            ok = 1'b1;
        end
        else begin
            ok = (wnd_byte == pattern[{sel[2:0], 3'b000} +: BYTE_W]);
        end
        return ok;
    endfunction

endpackage

// ===== design/bss_cell.sv =====
module bss_cell
    import bss_pkg::*;
#(
    parameter int BACK = 1
) (
    input  logic              clk,
    input  logic              shift_en,
    input  logic [BYTE_W-1:0] byte_in,
    input  logic [PAT_W-1:0]  pattern,
    input  logic [LEN_W-1:0]  len,
    output logic [BYTE_W-1:0] byte_out,
    output logic              ok
);

    logic [BYTE_W-1:0] wnd_reg;

    // hold one window byte, pass it on to the next cell as a new byte arrives
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            wnd_reg <= byte_in;
        end
    end

    assign byte_out = wnd_reg;
    assign ok       = byte_ok(pattern, len, 3'(BACK), wnd_reg);

endmodule

// ===== design/byte_substring_search.sv =====
// Streaming byte pattern search.
// Input channel: one text byte per word (in_valid / in_stall), last_byte marks
// the final byte of a text. Output channel: one word per text (out_valid /
// out_stall) carrying found, position and overflow, issued for the word that
// carried last_byte. Configuration: cfg_write with cfg_index and cfg_data,
// taken at any edge where cfg_write is high; write only between texts.
// Throughput: one text byte per cycle, except while a last byte is stalled. A row
// of MAX_PATTERN-1 cells holds the most recent bytes; every cell compares its byte
// in parallel, so a match is found in the cycle its final byte is accepted.
// Latency: the result word is valid the cycle after the last byte is accepted.
// Stall: the output register holds its word while out_stall is high; ordinary
// bytes keep flowing, only a new last byte is stalled until the word leaves.
// Reset: clears configuration (empty pattern, first-match, report start), the
// byte counter and the recorded match, and drops any pending result.
// Texts longer than MAX_TEXT bytes saturate the counter and set overflow.
module byte_substring_search
    import bss_pkg::*;
#(
    parameter int              MAX_PATTERN = 8,
    parameter longint unsigned MAX_TEXT    = 65536
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  bss_in_t              in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output bss_out_t             out_data,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PAT_W-1:0]     cfg_data
);

    localparam int CNT_W = $clog2(MAX_TEXT + 1);
    localparam int SUM_W = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

    logic [PAT_W-1:0] pattern_reg;
    logic [LEN_W-1:0] len_reg;
    logic             skip_reg;
    logic             search_last_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             seen_reg, seen_next;
    logic [POS_W-1:0] index_reg, index_next;
    logic             ovf_reg, ovf_next;

    logic             out_valid_reg, out_valid_next;
    bss_out_t         out_data_reg, out_data_next;

    logic             in_fire;
    logic [LEN_W-1:0] len_eff;
    logic [BYTE_W-1:0] chain [0:MAX_PATTERN-1];
    logic [MAX_PATTERN-1:0] ok;
    logic             idx_valid;
    logic [SUM_W-1:0] end_pos;
    logic [SUM_W-1:0] rep_pos;
    logic             match;

    assign in_stall = out_valid_reg & out_stall & in_data.last_byte;
    assign in_fire  = in_valid & ~in_stall;
    assign len_eff  = (len_reg > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_reg;

    // newest byte is compared straight from the input
    assign chain[0] = in_data.text_byte;
    assign ok[0]    = byte_ok(pattern_reg, len_eff, 3'd0, in_data.text_byte);

    genvar j;
    generate
        for (j = 0; j < MAX_PATTERN - 1; j++)
        begin : g_cell
            bss_cell #(
                .BACK(j + 1)
            ) u_cell (
                .clk     (clk),
                .shift_en(in_fire),
                .byte_in (chain[j]),
                .pattern (pattern_reg),
                .len     (len_eff),
                .byte_out(chain[j+1]),
                .ok      (ok[j+1])
            );
        end
    endgenerate

    assign idx_valid = (count_reg < CNT_W'(MAX_TEXT));
    assign end_pos   = SUM_W'(count_reg) + SUM_W'(1);
    assign rep_pos   = skip_reg ? end_pos : end_pos - SUM_W'(len_eff);
    assign match     = (len_eff != '0) && idx_valid && (end_pos >= SUM_W'(len_eff)) && (&ok);

    always_comb
    begin
        count_next     = count_reg;
        seen_next      = seen_reg;
        index_next     = index_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg & out_stall;
        out_data_next  = out_data_reg;
        if (in_fire)
        begin
            if (idx_valid)
            begin
                count_next = end_pos[CNT_W-1:0];
            end
            else
            begin
                ovf_next = 1'b1;
            end
            // record the match: first one only, or every one in last-match mode
            if (match && (!seen_reg || search_last_reg))
            begin
                seen_next  = 1'b1;
                index_next = rep_pos[POS_W-1:0];
            end
            if (in_data.last_byte)
            begin
                out_valid_next = 1'b1;
                if (len_eff == '0)
                begin
                    out_data_next.found    = 1'b1;
                    out_data_next.position = '0;
                end
                else
                begin
                    out_data_next.found    = seen_next;
                    out_data_next.position = seen_next ? index_next : '0;
                end
                out_data_next.overflow = ovf_next;
                // drop per-text state for the next text
                count_next = '0;
                seen_next  = 1'b0;
                index_next = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg     <= '0;
            len_reg         <= '0;
            skip_reg        <= 1'b0;
            search_last_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PATTERN_BYTES: pattern_reg     <= cfg_data;
                CFG_PATTERN_LEN:   len_reg         <= cfg_data[LEN_W-1:0];
                CFG_SKIP_MATCH:    skip_reg        <= cfg_data[0];
                CFG_SEARCH_LAST:   search_last_reg <= cfg_data[0];
                default:           pattern_reg     <= pattern_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            seen_reg      <= 1'b0;
            index_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            seen_reg      <= seen_next;
            index_reg     <= index_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== design/bss_checker.sv =====
module bss_checker
    import bss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_stall,
    input  bss_in_t  in_data,
    input  logic     out_valid,
    input  logic     out_stall,
    input  bss_out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result word changed or vanished while stalled");

    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> out_data.position == '0)
        else $error("nonzero position without a match");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && in_data.last_byte))
        else $error("result word without an accepted last byte");

    a_no_mid_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_data.last_byte |-> !in_stall)
        else $error("text byte stalled in the middle of a text");

endmodule

bind byte_substring_search bss_checker u_bss_checker (.*);
